FILE: hdl/rsd_pkg.sv
// Shared types, codes and calendar tables for the RTC snapshot decoder.
package rsd_pkg;

    // Configuration register indexes.
    localparam logic CFG_WEEKDAY_AT_EPOCH = 1'b0;
    localparam logic CFG_TIME_COMMITTED   = 1'b1;

    localparam logic [2:0] WEEKDAY_RESET = 3'd6;
    localparam logic [2:0] WEEKDAY_MOD   = 3'd7;

    localparam logic [31:0] SEC_PER_DAY  = 32'd86400;
    localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [16:0] SEC_PER_MIN  = 17'd60;
    localparam logic [15:0] DAYS_PER_YEAR = 16'd365;

    localparam int IN_W  = 64;
    localparam int OUT_W = 64;

    // Stage 1: decoded fields and validity checks.
    typedef struct packed {
        logic       stopped;
        logic       vlow;
        logic       digits;
        logic       cal;
        logic       leap_adj;
        logic [8:0] dbm;
        logic [2:0] wd;
        logic [7:0] yr;
        logic [4:0] mon;
        logic [6:0] day;
        logic [4:0] hr;
        logic [5:0] min;
        logic [5:0] sec;
    } t_s1;

    // Stage 2: day count and time-of-day seconds.
    typedef struct packed {
        logic        stopped;
        logic        vlow;
        logic        digits;
        logic        cal;
        logic [15:0] days;
        logic [16:0] hms;
        logic [2:0]  wd;
        logic [7:0]  yr;
        logic [4:0]  mon;
        logic [6:0]  day;
    } t_s2;

    // Stage 3: day seconds product and day count modulo seven.
    typedef struct packed {
        logic        stopped;
        logic        vlow;
        logic        digits;
        logic        cal;
        logic [31:0] day_secs;
        logic [16:0] hms;
        logic [2:0]  dmod;
        logic [2:0]  wd;
        logic [7:0]  yr;
        logic [4:0]  mon;
        logic [6:0]  day;
    } t_s3;

    // Output register contents.
    typedef struct packed {
        logic        stopped;
        logic        vlow;
        logic        digits;
        logic        cal;
        logic        wmatch;
        logic        hw;
        logic        utc;
        logic [31:0] secs;
        logic [7:0]  yr;
        logic [4:0]  mon;
        logic [6:0]  day;
    } t_out;

    function automatic logic [8:0] days_before_month(input logic [4:0] mon);
        logic [8:0] d;
        unique case (mon)
            5'd1:    d = 9'd0;
            5'd2:    d = 9'd31;
            5'd3:    d = 9'd59;
            5'd4:    d = 9'd90;
            5'd5:    d = 9'd120;
            5'd6:    d = 9'd151;
            5'd7:    d = 9'd181;
            5'd8:    d = 9'd212;
            5'd9:    d = 9'd243;
            5'd10:   d = 9'd273;
            5'd11:   d = 9'd304;
            5'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] month_length(input logic [4:0] mon);
        logic [4:0] l;
        unique case (mon)
            5'd2:                       l = 5'd28;
            5'd4, 5'd6, 5'd9, 5'd11:    l = 5'd30;
            default:                    l = 5'd31;
        endcase
        return l;
    endfunction

endpackage

FILE: hdl/rsd_bcd_digit.sv
// Two-digit BCD field decode: binary value and digit check.
module rsd_bcd_digit
    import rsd_pkg::*;
(
    input  logic [7:0] i_byte,
    output logic [7:0] o_value,
    output logic       o_ok
);

    logic [7:0] w_hi;

    // High digit times ten as (x << 3) + (x << 1).
    assign w_hi    = {1'b0, i_byte[7:4], 3'b000} + {3'b000, i_byte[7:4], 1'b0};
    assign o_value = w_hi + {4'b0000, i_byte[3:0]};
    assign o_ok    = (i_byte[7:4] <= 4'd9) && (i_byte[3:0] <= 4'd9);

endmodule

FILE: hdl/rtc_snapshot_decode_top.sv
// Top level of the RTC snapshot decoder: four-stage decode pipeline.
//
// Usage:
//   Slave stream s_axis_* carries one raw register snapshot per beat. The
//   master stream m_axis_* returns one decoded result per snapshot, in order.
//   The config channel (i_cfg_valid / o_cfg_ready) writes the epoch weekday
//   (index 0) and the time-committed flag (index 1); it is always ready and
//   must only be used while no snapshot is in flight.
// Pipeline and throughput:
//   A result reaches the master stream through the stage 1, 2 and 3
//   registers and the output register. One beat per cycle is sustained
//   while the receiver does not stall: stage 1 decodes and checks BCD,
//   stage 2 forms the day count, stage 3 multiplies by the seconds per day
//   and reduces the day count modulo seven, stage 4 is the output register.
// Reset:
//   Synchronous active-low reset empties the pipeline and sets the epoch
//   weekday to Saturday (6) and the committed flag to 0.
// Stall:
//   Each stage holds its beat while the next one is full and stalled;
//   empty stages keep filling, so up to four beats are taken before
//   s_axis_tready drops under a stalled receiver.
module rtc_snapshot_decode_top
    import rsd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // control, seconds, minutes, hours, days, weekday, months, years bytes
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // clock_stopped, voltage_low, digits_valid, calendar_valid,
    // weekday_matches, hardware_time_valid, utc_valid,
    // seconds_since_epoch[31:0], year_in_century[7:0], month_number[4:0],
    // day_number[6:0], zero padding[4:0]
    output logic [OUT_W-1:0] m_axis_tdata,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [2:0]       i_cfg_data
);

    logic [2:0] r_weekday_at_epoch;
    logic       r_time_committed;

    logic r_v1, r_v2, r_v3, r_v4;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    t_out r_out, n_out;

    logic w_adv1, w_adv2, w_adv3, w_adv4;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weekday_at_epoch <= WEEKDAY_RESET;
            r_time_committed   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WEEKDAY_AT_EPOCH: r_weekday_at_epoch <= i_cfg_data;
                CFG_TIME_COMMITTED:   r_time_committed   <= i_cfg_data[0];
                default:              ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    assign w_adv4 = !r_v4 || m_axis_tready;
    assign w_adv3 = !r_v3 || w_adv4;
    assign w_adv2 = !r_v2 || w_adv3;
    assign w_adv1 = !r_v1 || w_adv2;
    assign s_axis_tready = w_adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= s_axis_tvalid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
            if (w_adv4) r_v4 <= r_v3;
        end
    end

    // ---------------- stage 1: BCD decode and checks ----------------
    logic [7:0] w_ctrl, w_sraw;
    logic [7:0] w_sec_v, w_min_v, w_hr_v, w_day_v, w_mon_v, w_yr_v;
    logic       w_sec_ok, w_min_ok, w_hr_ok, w_day_ok, w_mon_ok, w_yr_ok;
    logic       w_leap, w_digits, w_range;
    logic [5:0] w_len;

    assign w_ctrl = s_axis_tdata[7:0];
    assign w_sraw = s_axis_tdata[15:8];

    rsd_bcd_digit u_sec (.i_byte({1'b0, w_sraw[6:0]}),
                         .o_value(w_sec_v), .o_ok(w_sec_ok));
    rsd_bcd_digit u_min (.i_byte({1'b0, s_axis_tdata[22:16]}),
                         .o_value(w_min_v), .o_ok(w_min_ok));
    rsd_bcd_digit u_hr  (.i_byte({2'b00, s_axis_tdata[29:24]}),
                         .o_value(w_hr_v), .o_ok(w_hr_ok));
    rsd_bcd_digit u_day (.i_byte({2'b00, s_axis_tdata[37:32]}),
                         .o_value(w_day_v), .o_ok(w_day_ok));
    rsd_bcd_digit u_mon (.i_byte({3'b000, s_axis_tdata[52:48]}),
                         .o_value(w_mon_v), .o_ok(w_mon_ok));
    rsd_bcd_digit u_yr  (.i_byte(s_axis_tdata[63:56]),
                         .o_value(w_yr_v), .o_ok(w_yr_ok));

    always_comb begin
        w_digits = w_sec_ok && w_min_ok && w_hr_ok && w_day_ok && w_mon_ok && w_yr_ok;
        w_leap   = (w_yr_v[1:0] == 2'b00);
        w_len    = {1'b0, month_length(w_mon_v[4:0])} +
                   {5'd0, (w_mon_v == 8'd2) && w_leap};
        w_range  = (w_yr_v <= 8'd99) && (w_mon_v >= 8'd1) && (w_mon_v <= 8'd12) &&
                   (w_day_v >= 8'd1) && (w_hr_v <= 8'd23) && (w_min_v <= 8'd59) &&
                   (w_sec_v <= 8'd59);

        n_s1.stopped  = w_ctrl[5];
        n_s1.vlow     = w_sraw[7];
        n_s1.digits   = w_digits;
        n_s1.cal      = w_digits && w_range && (w_day_v <= {2'b00, w_len});
        n_s1.leap_adj = (w_mon_v > 8'd2) && w_leap;
        n_s1.dbm      = days_before_month(w_mon_v[4:0]);
        n_s1.wd       = s_axis_tdata[42:40];
        n_s1.yr       = w_yr_v;
        n_s1.mon      = w_mon_v[4:0];
        n_s1.day      = w_day_v[6:0];
        n_s1.hr       = w_hr_v[4:0];
        n_s1.min      = w_min_v[5:0];
        n_s1.sec      = w_sec_v[5:0];
    end

    // ---------------- stage 2: day count and time of day ----------------
    logic [15:0] w_yr_days;
    logic [16:0] w_hr_secs;
    logic [16:0] w_min_secs;

    always_comb begin
        w_yr_days  = DAYS_PER_YEAR * {9'd0, r_s1.yr[6:0]};
        w_hr_secs  = SEC_PER_HOUR * {12'd0, r_s1.hr};
        w_min_secs = SEC_PER_MIN * {11'd0, r_s1.min};

        n_s2.stopped = r_s1.stopped;
        n_s2.vlow    = r_s1.vlow;
        n_s2.digits  = r_s1.digits;
        n_s2.cal     = r_s1.cal;
        // Leap days before this year: (yr + 3) / 4.
        n_s2.days    = w_yr_days + {7'd0, (9'({2'b00, r_s1.yr[6:0]}) + 9'd3) >> 2} +
                       {7'd0, r_s1.dbm} + {15'd0, r_s1.leap_adj} +
                       {11'd0, r_s1.day[4:0]} - 16'd1;
        n_s2.hms     = w_hr_secs + w_min_secs + {11'd0, r_s1.sec};
        n_s2.wd      = r_s1.wd;
        n_s2.yr      = r_s1.yr;
        n_s2.mon     = r_s1.mon;
        n_s2.day     = r_s1.day;
    end

    // ---------------- stage 3: day seconds and day count mod 7 ----------------
    logic [5:0] w_oct_sum;
    logic [3:0] w_oct_sum2;
    logic [47:0] w_prod;

    always_comb begin
        // 8 is 1 mod 7, so summing octal digits preserves the residue.
        w_oct_sum  = {3'd0, r_s2.days[2:0]} + {3'd0, r_s2.days[5:3]} +
                     {3'd0, r_s2.days[8:6]} + {3'd0, r_s2.days[11:9]} +
                     {3'd0, r_s2.days[14:12]} + {5'd0, r_s2.days[15]};
        w_oct_sum2 = {1'b0, w_oct_sum[2:0]} + {1'b0, w_oct_sum[5:3]};
        w_prod     = {32'd0, r_s2.days} * {16'd0, SEC_PER_DAY};

        n_s3.stopped  = r_s2.stopped;
        n_s3.vlow     = r_s2.vlow;
        n_s3.digits   = r_s2.digits;
        n_s3.cal      = r_s2.cal;
        n_s3.day_secs = w_prod[31:0];
        n_s3.hms      = r_s2.hms;
        n_s3.dmod     = (w_oct_sum2 >= {1'b0, WEEKDAY_MOD}) ?
                        3'(w_oct_sum2 - {1'b0, WEEKDAY_MOD}) : w_oct_sum2[2:0];
        n_s3.wd       = r_s2.wd;
        n_s3.yr       = r_s2.yr;
        n_s3.mon      = r_s2.mon;
        n_s3.day      = r_s2.day;
    end

    // ---------------- stage 4: final sum and weekday check ----------------
    logic [3:0] w_wk_sum;
    logic [2:0] w_wk;
    logic       w_wmatch, w_hw;

    always_comb begin
        w_wk_sum = {1'b0, r_weekday_at_epoch} + {1'b0, r_s3.dmod};
        w_wk     = (w_wk_sum >= {1'b0, WEEKDAY_MOD}) ?
                   3'(w_wk_sum - {1'b0, WEEKDAY_MOD}) : w_wk_sum[2:0];
        w_wmatch = r_s3.cal && (r_s3.wd != WEEKDAY_MOD) && (w_wk == r_s3.wd);
        w_hw     = !r_s3.stopped && !r_s3.vlow && r_s3.cal && w_wmatch;

        n_out.stopped = r_s3.stopped;
        n_out.vlow    = r_s3.vlow;
        n_out.digits  = r_s3.digits;
        n_out.cal     = r_s3.cal;
        n_out.wmatch  = w_wmatch;
        n_out.hw      = w_hw;
        n_out.utc     = w_hw && r_time_committed;
        n_out.secs    = r_s3.cal ? (r_s3.day_secs + {15'd0, r_s3.hms}) : 32'd0;
        n_out.yr      = r_s3.yr;
        n_out.mon     = r_s3.mon;
        n_out.day     = r_s3.day;
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_adv1) r_s1  <= n_s1;
        if (w_adv2) r_s2  <= n_s2;
        if (w_adv3) r_s3  <= n_s3;
        if (w_adv4) r_out <= n_out;
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {5'd0, r_out.day, r_out.mon, r_out.yr, r_out.secs,
                            r_out.utc, r_out.hw, r_out.wmatch, r_out.cal,
                            r_out.digits, r_out.vlow, r_out.stopped};

`ifndef ASSERT_OFF
    a_secs_need_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_out.secs != 32'd0)) |-> r_out.cal)
        else $error("nonzero seconds on an invalid calendar");

    a_utc_needs_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.utc) |-> (r_out.hw && r_out.wmatch && r_out.digits))
        else $error("utc_valid without valid hardware time");

    a_hw_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.hw) |-> (!r_out.stopped && !r_out.vlow && r_out.cal))
        else $error("hardware_time_valid with a bad flag");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && r_v1 && r_v2 && r_v3))
        else $error("input stalled while the pipeline has room");
`endif

endmodule

FILE: sim/tb_rtc_snapshot_decode_top.sv
// Self-checking testbench for the RTC snapshot decoder top level.
module tb_rtc_snapshot_decode_top
    import rsd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int NUM_PHASES      = 6;
    localparam int PRESSURE_PHASE  = 4;
    localparam int HOLD_CYCLES     = 80;
    localparam int DRAIN_CYCLES    = 10;

    typedef struct packed {
        logic        clock_stopped;
        logic        voltage_low;
        logic        digits_valid;
        logic        calendar_valid;
        logic        weekday_matches;
        logic        hw_time_valid;
        logic        utc_valid;
        logic [31:0] epoch_secs;
        logic [7:0]  year;
        logic [4:0]  month;
        logic [6:0]  day;
    } t_decoded;

    typedef struct packed {
        logic [63:0] snapshot;
        logic        has_typed;
        t_decoded    typed_result;
    } t_directed_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_index;
    logic [2:0]        i_cfg_data;

    // Shadow copy of the configuration registers.
    logic [2:0] epoch_weekday;
    logic       committed;

    t_decoded      expected_results[$];
    t_directed_row directed_rows[$];
    int            fail_count;
    int            cycle_count;
    int            phase_idx;
    int            send_idle_pct;
    int            rx_stall_pct;
    bit            pressure_done;

    rtc_snapshot_decode_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] make_snap(input logic [7:0] ctrl, input logic [7:0] sec,
                                              input logic [7:0] min, input logic [7:0] hr,
                                              input logic [7:0] day, input logic [7:0] wd,
                                              input logic [7:0] mon, input logic [7:0] yr);
        return {yr, mon, wd, day, hr, min, sec, ctrl};
    endfunction

    function automatic logic [7:0] to_bcd(input int unsigned v);
        logic [3:0] tens;
        logic [3:0] ones;
        tens = 4'(v / 10);
        ones = 4'(v % 10);
        return {tens, ones};
    endfunction

    function automatic logic digits_ok(input logic [7:0] v);
        return (v[3:0] <= 4'd9) && (v[7:4] <= 4'd9);
    endfunction

    function automatic int unsigned digits_value(input logic [7:0] v);
        return v[7:4] * 10 + v[3:0];
    endfunction

    function automatic int unsigned days_in_month(input int unsigned mon, input bit leap);
        int unsigned len;
        case (mon)
            2:             len = leap ? 29 : 28;
            4, 6, 9, 11:   len = 30;
            default:       len = 31;
        endcase
        return len;
    endfunction

    // Days from 2000-01-01 to the given date; every fourth year is a leap year.
    function automatic int unsigned days_since_epoch(input int unsigned yr,
                                                     input int unsigned mon,
                                                     input int unsigned day);
        int unsigned d;
        d = 365 * yr + (yr + 3) / 4;
        for (int unsigned m = 1; m < mon; m++)
            d += days_in_month(m, (yr % 4) == 0);
        return d + day - 1;
    endfunction

    function automatic t_decoded decode_snapshot(input logic [63:0] snap,
                                                 input logic [2:0] epoch_wd,
                                                 input logic commit_flag);
        t_decoded    r;
        logic [7:0]  b_sec, b_min, b_hr, b_day, b_mon, b_yr;
        logic [2:0]  wd;
        int unsigned sec, min, hr, day, mon, yr, days;
        logic        digits, cal, wmatch;
        b_sec = {1'b0, snap[14:8]};
        b_min = {1'b0, snap[22:16]};
        b_hr  = {2'b0, snap[29:24]};
        b_day = {2'b0, snap[37:32]};
        wd    = snap[42:40];
        b_mon = {3'b0, snap[52:48]};
        b_yr  = snap[63:56];
        digits = digits_ok(b_sec) && digits_ok(b_min) && digits_ok(b_hr) &&
                 digits_ok(b_day) && digits_ok(b_mon) && digits_ok(b_yr);
        sec = digits_value(b_sec);
        min = digits_value(b_min);
        hr  = digits_value(b_hr);
        day = digits_value(b_day);
        mon = digits_value(b_mon);
        yr  = digits_value(b_yr);
        cal = digits && yr <= 99 && mon >= 1 && mon <= 12 && day >= 1 && hr <= 23 &&
              min <= 59 && sec <= 59 && day <= days_in_month(mon, (yr % 4) == 0);
        days = cal ? days_since_epoch(yr, mon, day) : 0;
        // A weekday code of seven never matches; epoch register seven acts as Sunday.
        wmatch = cal && wd <= 3'd6 && ((epoch_wd + days) % 7) == wd;
        r.clock_stopped   = snap[5];
        r.voltage_low     = snap[15];
        r.digits_valid    = digits;
        r.calendar_valid  = cal;
        r.weekday_matches = wmatch;
        r.hw_time_valid   = !snap[5] && !snap[15] && cal && wmatch;
        r.utc_valid       = r.hw_time_valid && commit_flag;
        r.epoch_secs      = cal ? 32'(days * 86400 + hr * 3600 + min * 60 + sec) : 32'd0;
        r.year            = yr[7:0];
        r.month           = mon[4:0];
        r.day             = day[6:0];
        return r;
    endfunction

    // Mostly well-formed dates with random reserved bits, then in-range BCD
    // with out-of-range values, then raw noise.
    function automatic logic [63:0] random_snapshot(input logic [2:0] epoch_wd);
        int unsigned kind, yr, mon, day, hr, min, sec;
        logic [7:0]  ctrl, b_sec, b_wd, noise;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            yr  = $urandom_range(0, 99);
            mon = $urandom_range(1, 12);
            day = $urandom_range(1, days_in_month(mon, (yr % 4) == 0));
            hr  = $urandom_range(0, 23);
            min = $urandom_range(0, 59);
            sec = $urandom_range(0, 59);
            noise = 8'($urandom);
            ctrl = 8'($urandom);
            if ($urandom_range(0, 99) < 85)
                ctrl[5] = 1'b0;
            b_sec = to_bcd(sec);
            b_sec[7] = ($urandom_range(0, 99) < 10);
            if ($urandom_range(0, 99) < 75)
                b_wd = 8'((epoch_wd + days_since_epoch(yr, mon, day)) % 7);
            else
                b_wd = 8'($urandom_range(0, 7));
            b_wd[7:3] = noise[7:3];
            return make_snap(ctrl, b_sec, {noise[7], 7'(to_bcd(min))},
                             {noise[7:6], 6'(to_bcd(hr))}, {noise[6:5], 6'(to_bcd(day))},
                             b_wd, {noise[7:5], 5'(to_bcd(mon))}, to_bcd(yr));
        end else if (kind < 80) begin
            return make_snap(8'($urandom), to_bcd($urandom_range(0, 79)),
                             to_bcd($urandom_range(0, 79)), to_bcd($urandom_range(0, 39)),
                             to_bcd($urandom_range(0, 39)), 8'($urandom),
                             to_bcd($urandom_range(0, 19)), to_bcd($urandom_range(0, 99)));
        end
        return {$urandom, $urandom};
    endfunction

    task automatic send_snapshot(input logic [63:0] snap, input t_decoded expected);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = snap;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(expected);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic index, input logic [2:0] data);
        while (expected_results.size() != 0)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_WEEKDAY_AT_EPOCH)
            epoch_weekday = data;
        else
            committed = data[0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
        if (expected !== actual) begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, expected, actual);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_decoded exp_r;
        t_decoded got_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_r.clock_stopped   = m_axis_tdata[0];
            got_r.voltage_low     = m_axis_tdata[1];
            got_r.digits_valid    = m_axis_tdata[2];
            got_r.calendar_valid  = m_axis_tdata[3];
            got_r.weekday_matches = m_axis_tdata[4];
            got_r.hw_time_valid   = m_axis_tdata[5];
            got_r.utc_valid       = m_axis_tdata[6];
            got_r.epoch_secs      = m_axis_tdata[38:7];
            got_r.year            = m_axis_tdata[46:39];
            got_r.month           = m_axis_tdata[51:47];
            got_r.day             = m_axis_tdata[58:52];
            if (expected_results.size() == 0) begin
                fail_count++;
                $error("result beat with no snapshot outstanding: %h", m_axis_tdata);
            end else begin
                exp_r = expected_results.pop_front();
                check_field("clock_stopped", 32'(exp_r.clock_stopped),
                            32'(got_r.clock_stopped));
                check_field("voltage_low", 32'(exp_r.voltage_low),
                            32'(got_r.voltage_low));
                check_field("digits_valid", 32'(exp_r.digits_valid),
                            32'(got_r.digits_valid));
                check_field("calendar_valid", 32'(exp_r.calendar_valid),
                            32'(got_r.calendar_valid));
                check_field("weekday_matches", 32'(exp_r.weekday_matches),
                            32'(got_r.weekday_matches));
                check_field("hardware_time_valid", 32'(exp_r.hw_time_valid),
                            32'(got_r.hw_time_valid));
                check_field("utc_valid", 32'(exp_r.utc_valid),
                            32'(got_r.utc_valid));
                check_field("seconds_since_epoch", exp_r.epoch_secs, got_r.epoch_secs);
                check_field("year_in_century", 32'(exp_r.year), 32'(got_r.year));
                check_field("month_number", 32'(exp_r.month), 32'(got_r.month));
                check_field("day_number", 32'(exp_r.day), 32'(got_r.day));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL rtc_snapshot_decode_top");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off that backs up the pipeline.
    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (phase_idx == PRESSURE_PHASE && !pressure_done) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                pressure_done = 1'b1;
            end
            m_axis_tready = ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    initial begin
        logic [63:0] snap;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_WEEKDAY_AT_EPOCH;
        i_cfg_data    = '0;
        epoch_weekday = WEEKDAY_RESET;
        committed     = 1'b0;
        fail_count    = 0;
        cycle_count   = 0;
        phase_idx     = -1;
        send_idle_pct = 15;
        rx_stall_pct  = 68;
        pressure_done = 1'b0;

        // Reset-value configuration: epoch is Saturday, time not committed.
        directed_rows.push_back('{make_snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h06,
                                            8'h01, 8'h00),
                                  1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
                                          32'd0, 8'd0, 5'd1, 7'd1}});
        directed_rows.push_back('{make_snap(8'h00, 8'h59, 8'h59, 8'h23, 8'h31, 8'h04,
                                            8'h12, 8'h99),
                                  1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
                                          32'd3155759999, 8'd99, 5'd12, 7'd31}});
        directed_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                                  '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                    32'd0, 8'd165, 5'd25, 7'd45}});
        directed_rows.push_back('{64'h0, 1'b1,
                                  '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                                    32'd0, 8'd0, 5'd0, 7'd0}});
        // Leap days and month lengths.
        directed_rows.push_back('{make_snap(8'h00, 8'h56, 8'h34, 8'h12, 8'h29, 8'h02,
                                            8'h02, 8'h00), 1'b0, '0});
        directed_rows.push_back('{make_snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h29, 8'h04,
                                            8'h02, 8'h01), 1'b0, '0});
        directed_rows.push_back('{make_snap(8'h00, 8'h10, 8'h20, 8'h08, 8'h29, 8'h00,
                                            8'h02, 8'h04), 1'b0, '0});
        directed_rows.push_back('{make_snap(8'h00, 8'h59, 8'h59, 8'h23, 8'h28, 8'h03,
                                            8'h02, 8'h01), 1'b0, '0});
        directed_rows.push_back('{make_snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h31, 8'h01,
                                            8'h04, 8'h23), 1'b0, '0});
        directed_rows.push_back('{make_snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h31, 8'h02,
                                            8'h10, 8'h50), 1'b0, '0});
        // Out-of-range month, hour, minute, second and day.
        directed_rows.push_back('{make_snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00,
                                            8'h13, 8'h10), 1'b0, '0});
        directed_rows.push_back('{make_snap(8'h00, 8'h00, 8'h00, 8'h24, 8'h15, 8'h00,
                                            8'h06, 8'h10), 1'b0, '0});
        directed_rows.push_back('{make_snap(8'h00, 8'h00, 8'h60, 8'h10, 8'h15, 8'h00,
                                            8'h06, 8'h10), 1'b0, '0});
        directed_rows.push_back('{make_snap(8'h00, 8'h60, 8'h00, 8'h10, 8'h15, 8'h00,
                                            8'h06, 8'h10), 1'b0, '0});
        directed_rows.push_back('{make_snap(8'h00, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00,
                                            8'h06, 8'h10), 1'b0, '0});
        // Weekday code seven, stop bit, low-voltage flag, other control bits set.
        directed_rows.push_back('{make_snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h07,
                                            8'h01, 8'h00), 1'b0, '0});
        directed_rows.push_back('{make_snap(8'h20, 8'h00, 8'h00, 8'h00, 8'h01, 8'h06,
                                            8'h01, 8'h00), 1'b0, '0});
        directed_rows.push_back('{make_snap(8'h00, 8'hB0, 8'h00, 8'h00, 8'h01, 8'h06,
                                            8'h01, 8'h00), 1'b0, '0});
        directed_rows.push_back('{make_snap(8'hDF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h06,
                                            8'h01, 8'h00), 1'b0, '0});
        // Non-BCD digits still decode their nibble values.
        directed_rows.push_back('{make_snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00,
                                            8'h01, 8'h9A), 1'b0, '0});
        directed_rows.push_back('{make_snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00,
                                            8'h01, 8'hA0), 1'b0, '0});
        directed_rows.push_back('{make_snap(8'h00, 8'h00, 8'h00, 8'h2A, 8'h01, 8'h00,
                                            8'h01, 8'h05), 1'b0, '0});
        // Reserved bits set above a valid date must be ignored.
        directed_rows.push_back('{make_snap(8'h00, 8'h12, 8'hC5, 8'hE3, 8'hD5, 8'hFB,
                                            8'hE6, 8'h24), 1'b0, '0});

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            snap = directed_rows[i].snapshot;
            if (directed_rows[i].has_typed)
                send_snapshot(snap, directed_rows[i].typed_result);
            else
                send_snapshot(snap, decode_snapshot(snap, epoch_weekday, committed));
        end
        s_axis_tvalid = 1'b0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    write_register(CFG_WEEKDAY_AT_EPOCH, 3'd0);
                    write_register(CFG_TIME_COMMITTED, 3'd1);
                end
                1: write_register(CFG_WEEKDAY_AT_EPOCH, 3'd7);
                2: begin
                    write_register(CFG_WEEKDAY_AT_EPOCH, 3'd3);
                    write_register(CFG_TIME_COMMITTED, 3'd0);
                end
                3: write_register(CFG_WEEKDAY_AT_EPOCH, 3'd6);
                4: begin
                    write_register(CFG_WEEKDAY_AT_EPOCH, 3'd1);
                    write_register(CFG_TIME_COMMITTED, 3'd1);
                end
                default: write_register(CFG_WEEKDAY_AT_EPOCH, 3'd5);
            endcase
            if (p < 2) begin
                send_idle_pct = 15;
                rx_stall_pct  = 68;
            end else if (p < 4) begin
                send_idle_pct = 68;
                rx_stall_pct  = 15;
            end else begin
                send_idle_pct = 0;
                rx_stall_pct  = 0;
            end
            phase_idx = p;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                snap = random_snapshot(epoch_weekday);
                send_snapshot(snap, decode_snapshot(snap, epoch_weekday, committed));
            end
            s_axis_tvalid = 1'b0;
        end

        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS rtc_snapshot_decode_top");
        else
            $display("FAIL rtc_snapshot_decode_top");
        $finish;
    end

endmodule
